### rtl/jvp_pkg.sv
`default_nettype none
package jvp_pkg;

    localparam int NUM_JOINTS_DEF = 8;

    localparam int MUL_AW = 64;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DIV_NW = 96;
    localparam int DIV_DW = 34;
    localparam int STATE_W = 128;

    localparam logic [16:0] ONE_Q       = 17'd65536;
    localparam logic [33:0] NS_PER_S    = 34'd1000000000;
    localparam logic [31:0] DERIV_SCALE = 32'd1953125;
    localparam logic [95:0] DTERM_CAP   = 96'd1 << 50;

    localparam logic signed [31:0] RST_VGAIN  = 32'sd65536;
    localparam logic [16:0]        RST_ALPHA  = 17'd64881;
    localparam logic [30:0]        RST_KI     = 31'd6554;
    localparam logic [30:0]        RST_KD     = 31'd327680;
    localparam logic [30:0]        RST_ILIM   = 31'd65536;
    localparam logic [3:0]         RST_JOINTS = 4'd8;

    typedef enum logic [2:0] {
        CFG_VEL_GAIN = 3'd0,
        CFG_ALPHA    = 3'd1,
        CFG_KI       = 3'd2,
        CFG_KD       = 3'd3,
        CFG_ILIM     = 3'd4,
        CFG_JOINTS   = 3'd5
    } t_cfg_idx;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_LOAD = 17'h00002,
        S_M1   = 17'h00004,
        S_M2   = 17'h00008,
        S_FILT = 17'h00010,
        S_ERR  = 17'h00020,
        S_M3   = 17'h00040,
        S_D1   = 17'h00080,
        S_M4   = 17'h00100,
        S_D2   = 17'h00200,
        S_M5   = 17'h00400,
        S_M6   = 17'h00800,
        S_M7   = 17'h01000,
        S_M8   = 17'h02000,
        S_D3   = 17'h04000,
        S_SUM  = 17'h08000,
        S_WB   = 17'h10000
    } t_state;

    function automatic logic [63:0] f_mag64(input logic signed [63:0] v);
        f_mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    // round half away from zero on a magnitude, then drop 16 fraction bits
    function automatic logic [95:0] f_rnd16(input logic [95:0] m);
        f_rnd16 = (m + 96'd32768) >> 16;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            f_sat32 = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            f_sat32 = 32'sh80000000;
        end else begin
            f_sat32 = 32'(v);
        end
    endfunction

endpackage
`default_nettype wire

### rtl/jvp_ram.sv
`default_nettype none
module jvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/jvp_mul.sv
`default_nettype none
module jvp_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [jvp_pkg::MUL_AW-1:0]  i_a,
    input  wire logic [jvp_pkg::MUL_BW-1:0]  i_b,
    output logic      [jvp_pkg::MUL_PW-1:0]  o_product,
    output logic                             o_done
);

    localparam int CW = $clog2(jvp_pkg::MUL_BW);

    logic [jvp_pkg::MUL_AW-1:0] r_a;
    logic [jvp_pkg::MUL_PW-1:0] r_prod;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [jvp_pkg::MUL_AW:0]   n_sum;

    // one multiplier bit per cycle, shift-add from the low end
    assign n_sum = {1'b0, r_prod[jvp_pkg::MUL_PW-1:jvp_pkg::MUL_BW]}
                 + (r_prod[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{jvp_pkg::MUL_AW{1'b0}}, i_b};
            r_cnt  <= CW'(jvp_pkg::MUL_BW - 1);
        end else if (r_busy) begin
            r_prod <= {n_sum, r_prod[jvp_pkg::MUL_BW-1:1]};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_product = r_prod;
    assign o_done    = r_done;

endmodule
`default_nettype wire

### rtl/jvp_div.sv
`default_nettype none
module jvp_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [jvp_pkg::DIV_NW-1:0]  i_num,
    input  wire logic [jvp_pkg::DIV_DW-1:0]  i_den,
    output logic      [jvp_pkg::DIV_NW-1:0]  o_quotient,
    output logic                             o_done
);

    localparam int CW = $clog2(jvp_pkg::DIV_NW);

    logic [jvp_pkg::DIV_NW-1:0] r_q;
    logic [jvp_pkg::DIV_DW-1:0] r_rem;
    logic [jvp_pkg::DIV_DW-1:0] r_d;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [jvp_pkg::DIV_DW:0]   n_sh;
    logic [jvp_pkg::DIV_DW:0]   n_diff;
    logic                       n_ge;

    // restoring division, one quotient bit per cycle
    assign n_sh   = {r_rem, r_q[jvp_pkg::DIV_NW-1]};
    assign n_diff = n_sh - {1'b0, r_d};
    assign n_ge   = n_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num + jvp_pkg::DIV_NW'(i_den >> 1);
            r_rem <= '0;
            r_d   <= i_den;
            r_cnt <= CW'(jvp_pkg::DIV_NW - 1);
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[jvp_pkg::DIV_DW-1:0] : n_sh[jvp_pkg::DIV_DW-1:0];
            r_q   <= {r_q[jvp_pkg::DIV_NW-2:0], n_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule
`default_nettype wire

### rtl/joint_velocity_to_position_loop_core.sv
// A moving command runs every state from input word to result word; a hold command skips
// from the filter update to write-back; an ignored joint frees the input with no result.
// Words are taken one at a time, as the input stalls until write-back; the work is shared by one
// bit-serial multiplier (eight uses) and one bit-serial divider (three uses); output stalls hold it.
// Reset: synchronous, active low; control and configuration registers return to their
// defaults, all joint state reads as zero through per-joint valid flags, no clearing pass.
`default_nettype none
module joint_velocity_to_position_loop_core #(
    parameter int NUM_JOINTS = jvp_pkg::NUM_JOINTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_joint_number,
    input  wire logic signed [31:0] i_velocity_command,
    input  wire logic signed [31:0] i_measured_velocity,
    input  wire logic signed [31:0] i_measured_position,
    input  wire logic [26:0]        i_period_ns,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_joint_out,
    output logic signed [31:0]      o_position_drive,
    output logic                    o_drive_valid,
    output logic signed [31:0]      o_velocity_error,
    output logic signed [31:0]      o_smoothed_velocity,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    jvp_pkg::t_state r_state, n_state;

    logic signed [31:0] r_vgain;
    logic [16:0]        r_alpha;
    logic [30:0]        r_ki;
    logic [30:0]        r_kd;
    logic [30:0]        r_ilim;
    logic [3:0]         r_joints;

    logic [NUM_JOINTS-1:0] r_jvalid;
    logic                  r_go;
    logic                  r_out_valid;

    logic [2:0]         r_j;
    logic [AW-1:0]      r_addr;
    logic signed [31:0] r_cmd, r_mvel, r_mpos;
    logic [26:0]        r_period;
    logic signed [31:0] r_sp, r_int, r_prev, r_filt, r_err, r_t, r_drive;
    logic signed [32:0] r_derr;
    logic signed [49:0] r_acc;
    logic signed [47:0] r_ff, r_it;
    logic signed [51:0] r_dterm;
    logic               r_neg;
    logic               r_dvalid;

    logic [2:0]         r_o_joint;
    logic signed [31:0] r_o_drive, r_o_err, r_o_filt;
    logic               r_o_dvalid;

    logic        in_acc, joint_ok, wb_fire, is_mul, is_div, m_start, d_start, m_done, d_done;
    logic [16:0] a_eff;
    logic [jvp_pkg::MUL_AW-1:0]  m_a;
    logic [jvp_pkg::MUL_BW-1:0]  m_b;
    logic [jvp_pkg::MUL_PW-1:0]  m_prod;
    logic [jvp_pkg::DIV_DW-1:0]  d_den;
    logic [jvp_pkg::DIV_NW-1:0]  d_quo;
    logic [jvp_pkg::STATE_W-1:0] ram_rdata;

    logic [95:0]        n_q16;
    logic signed [63:0] n_filt_w, n_t, n_integ, n_lim, n_sum;
    logic signed [31:0] n_err;
    logic [95:0]        n_dcap;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != jvp_pkg::S_IDLE);
    assign in_acc      = i_valid && (r_state == jvp_pkg::S_IDLE);
    assign joint_ok    = ({1'b0, i_joint_number} < r_joints)
                      && (int'(i_joint_number) < NUM_JOINTS);
    assign wb_fire     = (r_state == jvp_pkg::S_WB) && (!r_out_valid || !i_stall);
    assign a_eff       = (r_alpha > jvp_pkg::ONE_Q) ? jvp_pkg::ONE_Q : r_alpha;

    assign is_mul = (r_state == jvp_pkg::S_M1) || (r_state == jvp_pkg::S_M2)
                 || (r_state == jvp_pkg::S_M3) || (r_state == jvp_pkg::S_M4)
                 || (r_state == jvp_pkg::S_M5) || (r_state == jvp_pkg::S_M6)
                 || (r_state == jvp_pkg::S_M7) || (r_state == jvp_pkg::S_M8);
    assign is_div = (r_state == jvp_pkg::S_D1) || (r_state == jvp_pkg::S_D2)
                 || (r_state == jvp_pkg::S_D3);
    assign m_start = is_mul && !r_go;
    assign d_start = is_div && !r_go;

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            jvp_pkg::S_M1: begin
                m_a = jvp_pkg::f_mag64(64'(r_filt));
                m_b = 32'(jvp_pkg::ONE_Q - a_eff);
            end
            jvp_pkg::S_M2: begin
                m_a = jvp_pkg::f_mag64(64'(r_mvel));
                m_b = 32'(a_eff);
            end
            jvp_pkg::S_M3: begin
                m_a = jvp_pkg::f_mag64(64'(r_err));
                m_b = 32'(r_period);
            end
            jvp_pkg::S_M4: begin
                m_a = jvp_pkg::f_mag64(64'(r_cmd));
                m_b = 32'(r_period);
            end
            jvp_pkg::S_M5: begin
                m_a = jvp_pkg::f_mag64(64'(r_t));
                m_b = 32'(jvp_pkg::f_mag64(64'(r_vgain)));
            end
            jvp_pkg::S_M6: begin
                m_a = jvp_pkg::f_mag64(64'(r_int));
                m_b = 32'(r_ki);
            end
            jvp_pkg::S_M7: begin
                m_a = jvp_pkg::f_mag64(64'(r_derr));
                m_b = 32'(r_kd);
            end
            jvp_pkg::S_M8: begin
                m_a = m_prod[jvp_pkg::MUL_AW-1:0];
                m_b = jvp_pkg::DERIV_SCALE;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign d_den = (r_state == jvp_pkg::S_D3) ? {r_period, 7'd0} : jvp_pkg::NS_PER_S;

    jvp_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (m_start),
        .i_a       (m_a),
        .i_b       (m_b),
        .o_product (m_prod),
        .o_done    (m_done)
    );

    jvp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (d_start),
        .i_num      (m_prod),
        .i_den      (d_den),
        .o_quotient (d_quo),
        .o_done     (d_done)
    );

    jvp_ram #(
        .WIDTH (jvp_pkg::STATE_W),
        .DEPTH (NUM_JOINTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wb_fire),
        .i_waddr (r_addr),
        .i_wdata ({r_sp, r_int, r_prev, r_filt}),
        .i_re    (in_acc),
        .i_raddr (AW'(i_joint_number)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jvp_pkg::S_IDLE: if (in_acc && joint_ok) n_state = jvp_pkg::S_LOAD;
            jvp_pkg::S_LOAD: n_state = jvp_pkg::S_M1;
            jvp_pkg::S_M1:   if (m_done) n_state = jvp_pkg::S_M2;
            jvp_pkg::S_M2:   if (m_done) n_state = jvp_pkg::S_FILT;
            jvp_pkg::S_FILT: n_state = (r_cmd == '0) ? jvp_pkg::S_WB : jvp_pkg::S_ERR;
            jvp_pkg::S_ERR:  n_state = jvp_pkg::S_M3;
            jvp_pkg::S_M3:   if (m_done) n_state = jvp_pkg::S_D1;
            jvp_pkg::S_D1:   if (d_done) n_state = jvp_pkg::S_M4;
            jvp_pkg::S_M4:   if (m_done) n_state = jvp_pkg::S_D2;
            jvp_pkg::S_D2:   if (d_done) n_state = jvp_pkg::S_M5;
            jvp_pkg::S_M5:   if (m_done) n_state = jvp_pkg::S_M6;
            jvp_pkg::S_M6:   if (m_done) n_state = jvp_pkg::S_M7;
            jvp_pkg::S_M7:   if (m_done) n_state = jvp_pkg::S_M8;
            jvp_pkg::S_M8:   if (m_done) n_state = jvp_pkg::S_D3;
            jvp_pkg::S_D3:   if (d_done) n_state = jvp_pkg::S_SUM;
            jvp_pkg::S_SUM:  n_state = jvp_pkg::S_WB;
            jvp_pkg::S_WB:   if (wb_fire) n_state = jvp_pkg::S_IDLE;
            default:         n_state = jvp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_q16    = jvp_pkg::f_rnd16(96'(jvp_pkg::f_mag64(64'(r_acc))));
        n_filt_w = r_acc[49] ? -$signed(n_q16[63:0]) : $signed(n_q16[63:0]);
        n_err    = jvp_pkg::f_sat32(64'(r_cmd) - 64'(r_filt));
        n_t      = r_neg ? -$signed(d_quo[63:0]) : $signed(d_quo[63:0]);
        n_integ  = 64'(r_int) + n_t;
        n_lim    = $signed({33'd0, r_ilim});
        if (n_integ > n_lim) begin
            n_integ = n_lim;
        end else if (n_integ < -n_lim) begin
            n_integ = -n_lim;
        end
        n_dcap = (d_quo > jvp_pkg::DTERM_CAP) ? jvp_pkg::DTERM_CAP : d_quo;
        n_sum  = 64'(r_sp) + 64'(r_ff) + 64'(r_it) + 64'(r_dterm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jvp_pkg::S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
            r_jvalid    <= '0;
            r_vgain     <= jvp_pkg::RST_VGAIN;
            r_alpha     <= jvp_pkg::RST_ALPHA;
            r_ki        <= jvp_pkg::RST_KI;
            r_kd        <= jvp_pkg::RST_KD;
            r_ilim      <= jvp_pkg::RST_ILIM;
            r_joints    <= jvp_pkg::RST_JOINTS;
        end else begin
            r_state <= n_state;
            if (m_start || d_start) begin
                r_go <= 1'b1;
            end else if (m_done || d_done) begin
                r_go <= 1'b0;
            end
            if (wb_fire) begin
                r_out_valid      <= 1'b1;
                r_jvalid[r_addr] <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    jvp_pkg::CFG_VEL_GAIN: r_vgain  <= $signed(i_cfg_data);
                    jvp_pkg::CFG_ALPHA:    r_alpha  <= i_cfg_data[16:0];
                    jvp_pkg::CFG_KI:       r_ki     <= i_cfg_data[30:0];
                    jvp_pkg::CFG_KD:       r_kd     <= i_cfg_data[30:0];
                    jvp_pkg::CFG_ILIM:     r_ilim   <= i_cfg_data[30:0];
                    jvp_pkg::CFG_JOINTS:   r_joints <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            jvp_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_j      <= i_joint_number;
                    r_addr   <= AW'(i_joint_number);
                    r_cmd    <= i_velocity_command;
                    r_mvel   <= i_measured_velocity;
                    r_mpos   <= i_measured_position;
                    r_period <= (i_period_ns == '0) ? 27'd1 : i_period_ns;
                end
            end
            jvp_pkg::S_LOAD: begin
                if (r_jvalid[r_addr]) begin
                    {r_sp, r_int, r_prev, r_filt} <= ram_rdata;
                end else begin
                    {r_sp, r_int, r_prev, r_filt} <= '0;
                end
            end
            jvp_pkg::S_M1: begin
                if (m_done) begin
                    r_acc <= r_filt[31] ? -$signed(m_prod[49:0]) : $signed(m_prod[49:0]);
                end
            end
            jvp_pkg::S_M2: begin
                if (m_done) begin
                    r_acc <= r_acc
                           + (r_mvel[31] ? -$signed(m_prod[49:0]) : $signed(m_prod[49:0]));
                end
            end
            jvp_pkg::S_FILT: begin
                r_filt <= jvp_pkg::f_sat32(n_filt_w);
                if (r_cmd == '0) begin
                    r_sp     <= r_mpos;
                    r_int    <= '0;
                    r_drive  <= '0;
                    r_err    <= '0;
                    r_dvalid <= 1'b0;
                end
            end
            jvp_pkg::S_ERR: begin
                r_err  <= n_err;
                r_derr <= 33'(n_err) - 33'(r_prev);
            end
            jvp_pkg::S_M3: if (m_done) r_neg <= r_err[31];
            jvp_pkg::S_D1: if (d_done) r_int <= 32'(n_integ);
            jvp_pkg::S_M4: if (m_done) r_neg <= r_cmd[31];
            jvp_pkg::S_D2: if (d_done) r_t <= 32'(n_t);
            jvp_pkg::S_M5: begin
                if (m_done) begin
                    r_ff <= 48'((r_t[31] ^ r_vgain[31])
                         ? -$signed(jvp_pkg::f_rnd16(m_prod))
                         : $signed(jvp_pkg::f_rnd16(m_prod)));
                end
            end
            jvp_pkg::S_M6: begin
                if (m_done) begin
                    r_it <= 48'(r_int[31]
                         ? -$signed(jvp_pkg::f_rnd16(m_prod))
                         : $signed(jvp_pkg::f_rnd16(m_prod)));
                end
            end
            jvp_pkg::S_M7: if (m_done) r_neg <= r_derr[32];
            jvp_pkg::S_M8: ;
            jvp_pkg::S_D3: begin
                if (d_done) begin
                    r_dterm <= 52'(r_neg ? -$signed(n_dcap) : $signed(n_dcap));
                end
            end
            jvp_pkg::S_SUM: begin
                r_sp     <= jvp_pkg::f_sat32(n_sum);
                r_drive  <= jvp_pkg::f_sat32(n_sum);
                r_prev   <= r_err;
                r_dvalid <= 1'b1;
            end
            jvp_pkg::S_WB: begin
                if (wb_fire) begin
                    r_o_joint  <= r_j;
                    r_o_drive  <= r_drive;
                    r_o_dvalid <= r_dvalid;
                    r_o_err    <= r_err;
                    r_o_filt   <= r_filt;
                end
            end
            default: ;
        endcase
    end

    assign o_valid             = r_out_valid;
    assign o_joint_out         = r_o_joint;
    assign o_position_drive    = r_o_drive;
    assign o_drive_valid       = r_o_dvalid;
    assign o_velocity_error    = r_o_err;
    assign o_smoothed_velocity = r_o_filt;

endmodule
`default_nettype wire

### verif/joint_velocity_to_position_loop_core_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module joint_velocity_to_position_loop_core_checker #(
    parameter int NUM_JOINTS = jvp_pkg::NUM_JOINTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_in_stall,
    input  wire logic [2:0]         i_joint_number,
    input  wire logic signed [31:0] i_velocity_command,
    input  wire logic signed [31:0] i_measured_velocity,
    input  wire logic signed [31:0] i_measured_position,
    input  wire logic [26:0]        i_period_ns,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [2:0]         i_joint_out,
    input  wire logic signed [31:0] i_position_drive,
    input  wire logic               i_drive_valid,
    input  wire logic signed [31:0] i_velocity_error,
    input  wire logic signed [31:0] i_smoothed_velocity,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output int                      o_fails,
    output int                      o_pending
);

    typedef struct packed {
        logic [2:0]  joint;
        logic [31:0] drive;
        logic        drive_valid;
        logic [31:0] verr;
        logic [31:0] smooth;
    } t_drive_word;

    t_drive_word drive_q[$];

    longint          ff_gain;
    longint unsigned alpha, ki, kd, ilim, joints;
    longint          setpoint[NUM_JOINTS];
    longint          integ_acc[NUM_JOINTS];
    longint          last_err[NUM_JOINTS];
    longint          filt_vel[NUM_JOINTS];

    function automatic longint round_div(longint n, longint unsigned d);
        longint unsigned m, q;
        m = n < 0 ? longint'(-n) : longint'(n);
        q = (m + d / 2) / d;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint deriv_term(longint gain, longint derr, longint unsigned per);
        longint          p, s;
        longint unsigned m, den, q1, r, v;
        p = gain * derr;
        m = p < 0 ? longint'(-p) : longint'(p);
        den = per * 128;
        q1 = m / den;
        r = m % den;
        if (q1 > (64'd1 << 29)) begin
            s = 64'sd1 << 50;
        end else begin
            v = q1 * 1953125 + (r * 1953125 + den / 2) / den;
            s = v > (64'd1 << 50) ? (64'sd1 << 50) : longint'(v);
        end
        return p < 0 ? -s : s;
    endfunction

    function automatic void predict_drive(logic [2:0] j, longint cmd, longint mvel,
                                          longint mpos, longint unsigned per);
        longint      a, filt, err, acc, ff, it, dterm, drive;
        t_drive_word w;
        err = 0;
        drive = 0;
        if (j >= joints || j >= NUM_JOINTS) return;
        if (per == 0) per = 1;
        a = alpha > 65536 ? 65536 : longint'(alpha);
        filt = clip32(round_div((65536 - a) * filt_vel[j] + a * mvel, 65536));
        filt_vel[j] = filt;
        if (cmd == 0) begin
            setpoint[j] = mpos;
            integ_acc[j] = 0;
        end else begin
            err = clip32(cmd - filt);
            acc = integ_acc[j] + round_div(err * longint'(per), 1000000000);
            if (acc > longint'(ilim)) acc = ilim;
            if (acc < -longint'(ilim)) acc = -longint'(ilim);
            integ_acc[j] = acc;
            ff = round_div(round_div(cmd * longint'(per), 1000000000) * ff_gain, 65536);
            it = round_div(acc * longint'(ki), 65536);
            dterm = deriv_term(longint'(kd), err - last_err[j], per);
            drive = clip32(setpoint[j] + ff + it + dterm);
            setpoint[j] = drive;
            last_err[j] = err;
        end
        w.joint = j;
        w.drive = drive[31:0];
        w.drive_valid = cmd != 0;
        w.verr = err[31:0];
        w.smooth = filt[31:0];
        drive_q.insert(drive_q.size(), w);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        o_fails++;
    endtask

    always @(posedge i_clk) begin
        t_drive_word w;
        if (!i_rst_n) begin
            ff_gain = jvp_pkg::RST_VGAIN;
            alpha = jvp_pkg::RST_ALPHA;
            ki = jvp_pkg::RST_KI;
            kd = jvp_pkg::RST_KD;
            ilim = jvp_pkg::RST_ILIM;
            joints = jvp_pkg::RST_JOINTS;
            for (int k = 0; k < NUM_JOINTS; k++) begin
                setpoint[k] = 0;
                integ_acc[k] = 0;
                last_err[k] = 0;
                filt_vel[k] = 0;
            end
            drive_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    jvp_pkg::CFG_VEL_GAIN: ff_gain = longint'($signed(i_cfg_data));
                    jvp_pkg::CFG_ALPHA:    alpha = i_cfg_data[16:0];
                    jvp_pkg::CFG_KI:       ki = i_cfg_data[30:0];
                    jvp_pkg::CFG_KD:       kd = i_cfg_data[30:0];
                    jvp_pkg::CFG_ILIM:     ilim = i_cfg_data[30:0];
                    jvp_pkg::CFG_JOINTS:   joints = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                predict_drive(i_joint_number, longint'(i_velocity_command),
                              longint'(i_measured_velocity), longint'(i_measured_position),
                              longint'(i_period_ns));
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("unexpected word, joint_out", 32'(i_joint_out), 32'd0);
                end else begin
                    w = drive_q.pop_front();
                    if (i_joint_out != w.joint)
                        report_mismatch("joint_out", 32'(i_joint_out), 32'(w.joint));
                    if (i_position_drive != w.drive)
                        report_mismatch("position_drive", i_position_drive, w.drive);
                    if (i_drive_valid != w.drive_valid)
                        report_mismatch("drive_valid", 32'(i_drive_valid), 32'(w.drive_valid));
                    if (i_velocity_error != w.verr)
                        report_mismatch("velocity_error", i_velocity_error, w.verr);
                    if (i_smoothed_velocity != w.smooth)
                        report_mismatch("smoothed_velocity", i_smoothed_velocity, w.smooth);
                end
            end
        end
        o_pending = drive_q.size();
    end

endmodule
`default_nettype wire

### verif/joint_velocity_to_position_loop_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module joint_velocity_to_position_loop_core_test;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         STALL_LIMIT = 30000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_joint_number;
    logic signed [31:0] i_velocity_command;
    logic signed [31:0] i_measured_velocity;
    logic signed [31:0] i_measured_position;
    logic [26:0]        i_period_ns;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_joint_out;
    logic signed [31:0] o_position_drive;
    logic               o_drive_valid;
    logic signed [31:0] o_velocity_error;
    logic signed [31:0] o_smoothed_velocity;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    int fails;
    int pending;
    int words_sent;
    int joints_now;
    int idle_cycles;

    joint_velocity_to_position_loop_core u_dut (.*);

    joint_velocity_to_position_loop_core_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_joint_number,
        .i_velocity_command, .i_measured_velocity, .i_measured_position, .i_period_ns,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_joint_out(o_joint_out),
        .i_position_drive(o_position_drive), .i_drive_valid(o_drive_valid),
        .i_velocity_error(o_velocity_error), .i_smoothed_velocity(o_smoothed_velocity),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fails(fails), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stall, one long hold-off, one quiet stretch
    initial begin
        int cyc;
        cyc = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 20000 && cyc < 23000) begin
                i_stall <= 1'b1;
            end else if (cyc >= 200000 && cyc < 260000) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= $urandom_range(99) < 21;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[joint_velocity_to_position_loop_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [2:0] j, input logic [31:0] cmd, input logic [31:0] mv,
                             input logic [31:0] mp, input logic [26:0] per);
        i_valid <= 1'b1;
        i_joint_number <= j;
        i_velocity_command <= cmd;
        i_measured_velocity <= mv;
        i_measured_position <= mp;
        i_period_ns <= per;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
        if (!(words_sent >= 500 && words_sent < 700) && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [2:0]  j;
        logic [31:0] cmd;
        logic [26:0] per;
        j = $urandom_range(99) < 10 ? 3'($urandom) : 3'($urandom_range(joints_now - 1));
        cmd = $urandom_range(99) < 25 ? 32'd0 : pick_q16();
        case ($urandom_range(9))
            0: per = 27'($urandom_range(1));
            1: per = 27'd100000000;
            2: per = 27'($urandom);
            default: per = 27'($urandom_range(100000, 10000000));
        endcase
        send_word(j, cmd, pick_q16(), pick_q16(), per);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_loop(input logic [31:0] vg, input logic [31:0] al, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [31:0] lim,
                            input logic [31:0] nj);
        drain();
        write_reg(jvp_pkg::CFG_VEL_GAIN, vg);
        write_reg(jvp_pkg::CFG_ALPHA, al);
        write_reg(jvp_pkg::CFG_KI, ki);
        write_reg(jvp_pkg::CFG_KD, kd);
        write_reg(jvp_pkg::CFG_ILIM, lim);
        write_reg(jvp_pkg::CFG_JOINTS, nj);
        write_reg(CFG_UNUSED, $urandom);
        joints_now = nj[3:0] == 0 ? 1 : (nj[3:0] > 8 ? 8 : nj[3:0]);
    endtask

    initial begin
        words_sent = 0;
        joints_now = 8;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_joint_number = '0;
        i_velocity_command = '0;
        i_measured_velocity = '0;
        i_measured_position = '0;
        i_period_ns = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(3'd0, 32'sh00010000, 32'sh00008000, 32'sh00050000, 27'd1000000);
        send_word(3'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 27'd0);
        send_word(3'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 27'd1);
        send_word(3'd0, 32'd0, 32'sh7fffffff, 32'sh12345678, 27'd1000000);
        send_word(3'd7, 32'sh80000000, 32'sh80000000, 32'sh80000000, 27'd100000000);
        send_word(3'd7, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 27'h7ffffff);
        send_word(3'd7, 32'd0, 32'd0, 32'sh80000000, 27'd0);
        send_word(3'd3, 32'sh00000001, 32'shffffffff, 32'd0, 27'd1);
        send_word(3'd3, 32'shffffffff, 32'sh00000001, 32'd0, 27'd1);
        send_word(3'd5, 32'sh00020000, 32'sh00010000, 32'shfffe0000, 27'd500000);
        send_word(3'd5, 32'sh00020000, 32'sh00010000, 32'shfffe0000, 27'd500000);
        send_word(3'd5, 32'sh00020000, 32'sh00010000, 32'shfffe0000, 27'd500000);
        repeat (200) send_random();

        set_loop(32'h7fffffff, 32'h1ffff, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'hf);
        repeat (200) send_random();

        set_loop(32'h80000000, 32'h0, 32'hffffffff, 32'h0, 32'h0, 32'h1);
        send_word(3'd7, 32'sh00010000, 32'd0, 32'd0, 27'd1000);
        send_word(3'd1, 32'sh00010000, 32'd0, 32'd0, 27'd1000);
        send_word(3'd0, 32'sh00010000, 32'sh7fffffff, 32'd0, 27'd1000);
        repeat (150) send_random();

        set_loop($urandom, $urandom_range(65536), $urandom, $urandom, $urandom,
                 $urandom_range(1, 8));
        repeat (250) send_random();

        set_loop($urandom, 32'd65536, $urandom_range(20000), $urandom_range(1000000),
                 $urandom_range(1 << 20), 32'd0);
        repeat (8) send_random();

        set_loop(32'h10000, 32'd60000, 32'd6554, 32'd327680, 32'd65536, 32'd8);
        repeat (400) send_random();

        drain();
        repeat (600) @(posedge i_clk);
        if (fails == 0) begin
            $display("[joint_velocity_to_position_loop_core] OK");
        end else begin
            $display("[joint_velocity_to_position_loop_core] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
